### hdl/triangle_tangent_vector_defines.svh
// ---------------------------------------------------------------------------
// Triangle tangent vector: assertion macros
// Shared property forms for the checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef TRIANGLE_TANGENT_VECTOR_DEFINES_SVH
`define TRIANGLE_TANGENT_VECTOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TTV_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define TTV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### hdl/ttv_pkg.sv
// ---------------------------------------------------------------------------
// Triangle tangent vector: package
// Shared constants and the sequencer state type.
// ---------------------------------------------------------------------------
package ttv_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int OUT_WIDTH       = 16;
  localparam int UNIT_Q14        = 16384;
  localparam int NORM_WIDTH      = 30;  // normalized magnitudes stay below 2^30
  localparam int FRAC_SHIFT      = 15;  // a * 32768 in the rounding divide

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MUL   = 8'b0000_0010,
    S_CHECK = 8'b0000_0100,
    S_SHIFT = 8'b0000_1000,
    S_SQ    = 8'b0001_0000,
    S_SQRT  = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } ttv_state_t;

endpackage

### hdl/ttv_mul.sv
// ---------------------------------------------------------------------------
// Triangle tangent vector: shared multiplier
// Signed multiplier with a registered product.
// ---------------------------------------------------------------------------
module ttv_mul #(
  parameter int MULW = 31
) (
  input  logic                     clk,
  input  logic signed [MULW-1:0]   a,
  input  logic signed [MULW-1:0]   b,
  output logic signed [2*MULW-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

### hdl/triangle_tangent_vector.sv
// ---------------------------------------------------------------------------
// Triangle tangent vector
// Per-triangle unit tangent from a stream of textured vertices.
// ---------------------------------------------------------------------------
// Every three accepted vertices form a triangle. The first two are stored,
// and the block is ready again at once. The third starts a
// sequence on one shared multiplier plus an add/compare datapath:
//   - products for the determinant and the edge combination,
//   - a check,
//   - a normalizing shift, one bit per step (at most
//     2*COORD_WIDTH-29 bits),
//   - squares of the three magnitudes,
//   - a bit-serial square root,
//   - a rounding divide for each of the three components,
//   - a hand-over of the result to the output register.
// After the third vertex, in_stall stays high through this sequence; a
// degenerate triangle goes from the check to the hand-over. It stays high
// longer while the previous tangent still waits for its transfer. The result
// register lets the next vertices enter while a finished tangent still waits
// for its transfer. A zero texture determinant or a zero edge combination
// gives degenerate = 1 and a zero tangent.
module triangle_tangent_vector #(
  parameter int COORD_WIDTH = ttv_pkg::COORD_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [COORD_WIDTH-1:0]          pos_x,
  input  logic signed [COORD_WIDTH-1:0]          pos_y,
  input  logic signed [COORD_WIDTH-1:0]          pos_z,
  input  logic signed [COORD_WIDTH-1:0]          tex_u,
  input  logic signed [COORD_WIDTH-1:0]          tex_v,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [ttv_pkg::OUT_WIDTH-1:0]   tangent_x,
  output logic signed [ttv_pkg::OUT_WIDTH-1:0]   tangent_y,
  output logic signed [ttv_pkg::OUT_WIDTH-1:0]   tangent_z,
  output logic                                   degenerate
);

  `include "triangle_tangent_vector_defines.svh"

  import ttv_pkg::*;

  localparam int W    = COORD_WIDTH;
  localparam int DW   = W + 1;
  localparam int TW   = 2 * W + 3;
  localparam int AW   = (TW > NORM_WIDTH + 1) ? TW : NORM_WIDTH + 1;
  localparam int MULW = (DW > NORM_WIDTH + 1) ? DW : NORM_WIDTH + 1;
  localparam int SUMW = 2 * NORM_WIDTH + 2;
  localparam int RW   = SUMW + 1;
  localparam int NRW  = NORM_WIDTH + 1;
  localparam int NUMW = NORM_WIDTH + FRAC_SHIFT + 1;
  localparam int DVW  = NRW + 2;
  localparam int QW   = FRAC_SHIFT;

  ttv_state_t state;
  logic [1:0] phase;

  logic signed [W-1:0] h_pos [6];
  logic signed [W-1:0] h_tex [4];

  logic signed [DW-1:0] du1, dv1, du2, dv2;
  logic signed [DW-1:0] e1 [3];
  logic signed [DW-1:0] e2 [3];

  logic signed [TW-1:0] acc, det;
  logic signed [TW-1:0] tv [3];
  logic [AW-1:0] mag [3];
  logic [2:0]    neg;
  logic [3:0]    k;

  logic [SUMW-1:0] sum;
  logic [RW-1:0]   sx, sr;
  logic [4:0]      sk;

  logic [NRW-1:0]          nrm;
  logic [QW-1:0]           nbits;
  logic [DVW-1:0]          rem;
  logic [QW-1:0]           quo;
  logic [3:0]              dstep;
  logic [1:0]              di;
  logic signed [OUT_WIDTH-1:0] res [3];
  logic                    res_deg;

  logic signed [MULW-1:0]   mul_a, mul_b;
  logic signed [2*MULW-1:0] prod;

  logic in_xfer, out_xfer;
  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  ttv_mul #(.MULW(MULW)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // Operand selection for the shared multiplier.
  logic [1:0] ei;
  always_comb begin
    ei    = k[2:1] - 2'd1;
    mul_a = '0;
    mul_b = '0;
    if (state == S_MUL && k != 4'd8) begin
      if (k[3:1] == 3'd0) begin
        mul_a = k[0] ? MULW'(du2) : MULW'(du1);
        mul_b = k[0] ? MULW'(dv1) : MULW'(dv2);
      end else begin
        mul_a = k[0] ? MULW'(dv1) : MULW'(dv2);
        mul_b = k[0] ? MULW'(e2[ei]) : MULW'(e1[ei]);
      end
    end else if (state == S_SQ && k[1:0] != 2'd3) begin
      mul_a = MULW'(mag[k[1:0]][NORM_WIDTH-1:0]);
      mul_b = MULW'(mag[k[1:0]][NORM_WIDTH-1:0]);
    end
  end

  logic [3:0] j;
  logic signed [TW-1:0] pdiff;
  logic [1:0] ti;
  assign j     = k - 4'd1;
  assign pdiff = acc - TW'(prod);
  assign ti    = j[2:1] - 2'd1;

  logic [RW-1:0] sbit, stry;
  assign sbit = RW'(1) << {sk, 1'b0};
  assign stry = sr + sbit;

  logic [NUMW-1:0] num_c;
  logic [DVW:0]    rsh;
  logic [DVW-1:0]  dv;
  logic            qb;
  logic [QW-1:0]   quo_next;
  logic [OUT_WIDTH-1:0] qext;
  assign nrm      = (sr[NRW-1:0] == '0) ? NRW'(1) : sr[NRW-1:0];
  assign num_c    = NUMW'({mag[di][NORM_WIDTH-1:0], {FRAC_SHIFT{1'b0}}}) + NUMW'(nrm);
  assign dv       = {1'b0, nrm, 1'b0};
  assign rsh      = {rem, nbits[QW-1]};
  assign qb       = (rsh >= {1'b0, dv});
  assign quo_next = {quo[QW-2:0], qb};
  assign qext     = OUT_WIDTH'(quo_next);

  logic any_high;
  always_comb begin
    any_high = 1'b0;
    for (int i = 0; i < 3; i++) begin
      any_high = any_high | (|mag[i][AW-1:NORM_WIDTH]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (out_xfer && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (phase == 2'd0) begin
              h_pos[0] <= pos_x; h_pos[1] <= pos_y; h_pos[2] <= pos_z;
              h_tex[0] <= tex_u; h_tex[1] <= tex_v;
              phase <= 2'd1;
            end else if (phase == 2'd1) begin
              h_pos[3] <= pos_x; h_pos[4] <= pos_y; h_pos[5] <= pos_z;
              h_tex[2] <= tex_u; h_tex[3] <= tex_v;
              phase <= 2'd2;
            end else begin
              du1   <= DW'(h_tex[2]) - DW'(h_tex[0]);
              dv1   <= DW'(h_tex[3]) - DW'(h_tex[1]);
              du2   <= DW'(tex_u) - DW'(h_tex[0]);
              dv2   <= DW'(tex_v) - DW'(h_tex[1]);
              e1[0] <= DW'(h_pos[3]) - DW'(h_pos[0]);
              e1[1] <= DW'(h_pos[4]) - DW'(h_pos[1]);
              e1[2] <= DW'(h_pos[5]) - DW'(h_pos[2]);
              e2[0] <= DW'(pos_x) - DW'(h_pos[0]);
              e2[1] <= DW'(pos_y) - DW'(h_pos[1]);
              e2[2] <= DW'(pos_z) - DW'(h_pos[2]);
              k     <= 4'd0;
              phase <= 2'd0;
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          // Product k-1 arrives while operand pair k is issued.
          k <= k + 4'd1;
          if (k != 4'd0) begin
            if (!j[0]) begin
              acc <= TW'(prod);
            end else if (j[3:1] == 3'd0) begin
              det <= pdiff;
            end else begin
              tv[ti] <= pdiff;
            end
          end
          if (k == 4'd8) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (det == '0 || (tv[0] == '0 && tv[1] == '0 && tv[2] == '0)) begin
            res[0]  <= '0;
            res[1]  <= '0;
            res[2]  <= '0;
            res_deg <= 1'b1;
            state   <= S_EMIT;
          end else begin
            for (int i = 0; i < 3; i++) begin
              mag[i] <= AW'(tv[i][TW-1] ? TW'(-tv[i]) : tv[i]);
              neg[i] <= tv[i][TW-1] ^ det[TW-1];
            end
            res_deg <= 1'b0;
            state   <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (any_high) begin
            for (int i = 0; i < 3; i++) begin
              mag[i] <= mag[i] >> 1;
            end
          end else begin
            k     <= 4'd0;
            sum   <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          k <= k + 4'd1;
          if (k != 4'd0) begin
            sum <= sum + prod[SUMW-1:0];
          end
          if (k == 4'd3) begin
            sx    <= RW'(sum + prod[SUMW-1:0]);
            sr    <= '0;
            sk    <= 5'd31;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sx >= stry) begin
            sx <= sx - stry;
            sr <= (sr >> 1) + sbit;
          end else begin
            sr <= sr >> 1;
          end
          sk <= sk - 5'd1;
          if (sk == 5'd0) begin
            di    <= 2'd0;
            dstep <= 4'd0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (dstep == 4'd0) begin
            // The quotient stays below 2^15, so the top bits are a valid
            // starting remainder.
            rem   <= DVW'(num_c[NUMW-1:QW]);
            nbits <= num_c[QW-1:0];
            quo   <= '0;
            dstep <= 4'd1;
          end else begin
            rem   <= qb ? DVW'(rsh - {1'b0, dv}) : rsh[DVW-1:0];
            nbits <= nbits << 1;
            quo   <= quo_next;
            // Fifteen quotient bits per component, then the next one.
            if (dstep == 4'(QW)) begin
              res[di] <= neg[di] ? OUT_WIDTH'(-qext) : qext;
              dstep   <= 4'd0;
              if (di == 2'd2) begin
                state <= S_EMIT;
              end else begin
                di <= di + 2'd1;
              end
            end else begin
              dstep <= dstep + 4'd1;
            end
          end
        end
        S_EMIT: begin
          if (!out_valid || out_xfer) begin
            out_valid  <= 1'b1;
            tangent_x  <= res[0];
            tangent_y  <= res[1];
            tangent_z  <= res[2];
            degenerate <= res_deg;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `TTV_ASSERT_NOW(a_deg_zero, clk, rst, out_valid && degenerate,
    tangent_x == '0 && tangent_y == '0 && tangent_z == '0)
  `TTV_ASSERT_NOW(a_unit_range, clk, rst, out_valid,
    tangent_x >= -16'sd16384 && tangent_x <= 16'sd16384 && tangent_y >= -16'sd16384)
  `TTV_ASSERT_NEXT(a_third_starts, clk, rst, in_valid && !in_stall && phase == 2'd2,
    state == S_MUL && phase == 2'd0)

endmodule
